>>> rtl/dmhq_pkg.sv
// ----------------------------------------------------------------------------
// dmhq_pkg
// Shared types and constants for the d-ary min-heap priority queue.
// ----------------------------------------------------------------------------
package dmhq_pkg;

  localparam int unsigned DefCapacity = 256;
  localparam int unsigned DefKeyWidth = 32;
  localparam int unsigned DefTagWidth = 16;
  localparam int unsigned DefMaxArity = 8;

  localparam int unsigned ArityReset = 2;
  localparam int unsigned ArityMin   = 2;

  // register byte addresses
  localparam logic [1:0] RegArityAddr = 2'd0;

  typedef enum logic [1:0] {
    ModeInsert = 2'd0,
    ModeRemove = 2'd1,
    ModePeek   = 2'd2,
    ModeNop    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2,
    StatusRsvd  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StUpChk,
    StUpFix,
    StUpCmp,
    StRoot,
    StLast,
    StDnFirst,
    StDnRd,
    StDnWait,
    StDnDec,
    StDone
  } state_e;

endpackage

>>> rtl/dary_min_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// dary_min_heap_queue_unit
// d-ary min-heap priority queue over key/tag pairs, held in one
// synchronous single-port entry memory with read-modify-write sifting.
// ----------------------------------------------------------------------------
// Sequencing: an error or no-op goes straight to the result, and peek reads the root;
//   insert climbs level by level (parent index, parent read, compare and write);
//   remove reads the root and the last entry, then descends level by level,
//   reading the children of a level one by one through the memory port.
// Throughput: one item at a time, the next accepted in the cycle after the result loads.
// Reset: clears fill count, arity (to 2) and control state, not the entry memory.
module dary_min_heap_queue_unit #(
  parameter int unsigned CAPACITY  = dmhq_pkg::DefCapacity,
  parameter int unsigned KEY_WIDTH = dmhq_pkg::DefKeyWidth,
  parameter int unsigned TAG_WIDTH = dmhq_pkg::DefTagWidth,
  parameter int unsigned MAX_ARITY = dmhq_pkg::DefMaxArity,
  localparam int unsigned CW   = $clog2(CAPACITY + 1),
  localparam int unsigned INW  = ((2 + KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUTW = ((KEY_WIDTH + TAG_WIDTH + 2 + CW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [INW-1:0]  s_axis_tdata,   // mode, key, tag (from bit 0 up)
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OUTW-1:0] m_axis_tdata,   // out_key, out_tag, status, fill
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned AW  = $clog2(MAX_ARITY + 1);
  localparam int unsigned EW  = KEY_WIDTH + TAG_WIDTH;
  localparam int unsigned SH  = IW + 4;
  localparam int unsigned RW  = SH;
  localparam int unsigned FW  = IW + AW + 1;

  typedef logic [EW-1:0] entry_t;

  // entry memory: {key, tag}
  entry_t mem_q [CAPACITY];
  entry_t rd_data_q;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // reciprocal table for the parent index: floor(2^SH / a)
  logic [RW-1:0] recip_tab [MAX_ARITY+1];
  assign recip_tab[0] = '0;
  assign recip_tab[1] = '0;
  for (genvar g = 2; g <= MAX_ARITY; g++) begin : g_recip
    localparam logic [RW-1:0] Recip = RW'((64'd1 << SH) / g);
    assign recip_tab[g] = Recip;
  end

  dmhq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   arity_q, arity_d;
  logic [1:0]      mode_q, mode_d;
  entry_t          hold_q, hold_d;
  entry_t          best_q, best_d;
  logic            best_v_q, best_v_d;
  logic [IW-1:0]   best_idx_q, best_idx_d;
  logic [IW-1:0]   pos_q, pos_d;
  logic [IW-1:0]   quo_q, quo_d;
  logic [IW-1:0]   par_q, par_d;
  logic [IW-1:0]   ch_q, ch_d;
  logic [IW-1:0]   ch_end_q, ch_end_d;
  logic            rdv_q, rdv_d;
  logic [IW-1:0]   rd_idx_q, rd_idx_d;
  logic [KEY_WIDTH-1:0] res_key_q, res_key_d;
  logic [TAG_WIDTH-1:0] res_tag_q, res_tag_d;
  logic [1:0]      res_st_q, res_st_d;

  logic            out_valid_q, out_valid_d;
  logic [OUTW-1:0] out_data_q, out_data_d;

  logic [1:0]           in_mode;
  logic [KEY_WIDTH-1:0] in_key;
  logic [TAG_WIDTH-1:0] in_tag;
  logic                 s_accept, cfg_wr;
  logic [IW-1:0]        x_val;
  logic [IW+RW-1:0]     prod;
  logic [IW+AW-1:0]     rem;
  logic [IW-1:0]        parent;
  logic [FW-1:0]        first_c, last_c;
  logic [AW-1:0]        cfg_val;
  logic                 load_out;

  assign in_mode  = s_axis_tdata[1:0];
  assign in_key   = s_axis_tdata[2 +: KEY_WIDTH];
  assign in_tag   = s_axis_tdata[2 + KEY_WIDTH +: TAG_WIDTH];
  assign s_axis_tready = (state_q == dmhq_pkg::StIdle);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == dmhq_pkg::RegArityAddr);
  assign prdata = 32'(arity_q);

  always_comb begin
    if ({1'b0, pwdata[3:0]} < 5'(dmhq_pkg::ArityMin)) begin
      cfg_val = AW'(dmhq_pkg::ArityMin);
    end else if ({1'b0, pwdata[3:0]} > 5'(MAX_ARITY)) begin
      cfg_val = AW'(MAX_ARITY);
    end else begin
      cfg_val = AW'(pwdata[3:0]);
    end
  end

  assign x_val  = pos_q - IW'(1);
  assign prod   = (IW+RW)'(x_val) * (IW+RW)'(recip_tab[arity_q]);
  assign rem    = (IW+AW)'(x_val) - (IW+AW)'(quo_q) * (IW+AW)'(arity_q);
  assign parent = (rem >= (IW+AW)'(arity_q)) ? quo_q + IW'(1) : quo_q;
  assign first_c = FW'(pos_q) * FW'(arity_q) + FW'(1);
  assign last_c  = first_c + FW'(arity_q) - FW'(1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    arity_d    = arity_q;
    mode_d     = mode_q;
    hold_d     = hold_q;
    best_d     = best_q;
    best_v_d   = best_v_q;
    best_idx_d = best_idx_q;
    pos_d      = pos_q;
    quo_d      = quo_q;
    par_d      = par_q;
    ch_d       = ch_q;
    ch_end_d   = ch_end_q;
    rdv_d      = 1'b0;
    rd_idx_d   = rd_idx_q;
    res_key_d  = res_key_q;
    res_tag_d  = res_tag_q;
    res_st_d   = res_st_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_data    = hold_q;
    load_out   = 1'b0;

    if (cfg_wr && (count_q == '0)) begin
      arity_d = cfg_val;
    end

    // fold in the child read issued last cycle
    if (rdv_q && (!best_v_q ||
        (rd_data_q[EW-1 -: KEY_WIDTH] < best_q[EW-1 -: KEY_WIDTH]))) begin
      best_d     = rd_data_q;
      best_idx_d = rd_idx_q;
      best_v_d   = 1'b1;
    end

    case (state_q)
      dmhq_pkg::StIdle: begin
        if (s_accept) begin
          mode_d    = in_mode;
          res_key_d = '0;
          res_tag_d = '0;
          res_st_d  = dmhq_pkg::StatusOk;
          case (in_mode)
            dmhq_pkg::ModeInsert: begin
              if (count_q >= CW'(CAPACITY)) begin
                res_st_d = dmhq_pkg::StatusFull;
                state_d  = dmhq_pkg::StDone;
              end else begin
                hold_d  = {in_key, in_tag};
                pos_d   = IW'(count_q);
                count_d = count_q + CW'(1);
                state_d = dmhq_pkg::StUpChk;
              end
            end
            dmhq_pkg::ModeRemove, dmhq_pkg::ModePeek: begin
              if (count_q == '0) begin
                res_st_d = dmhq_pkg::StatusEmpty;
                state_d  = dmhq_pkg::StDone;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = dmhq_pkg::StRoot;
              end
            end
            default: state_d = dmhq_pkg::StDone;
          endcase
        end
      end
      dmhq_pkg::StUpChk: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = dmhq_pkg::StDone;
        end else begin
          quo_d   = IW'(prod >> SH);
          state_d = dmhq_pkg::StUpFix;
        end
      end
      dmhq_pkg::StUpFix: begin
        rd_en   = 1'b1;
        rd_addr = parent;
        par_d   = parent;
        state_d = dmhq_pkg::StUpCmp;
      end
      dmhq_pkg::StUpCmp: begin
        wr_en = 1'b1;
        if (rd_data_q[EW-1 -: KEY_WIDTH] > hold_q[EW-1 -: KEY_WIDTH]) begin
          // move the parent down into the hole and climb
          wr_data = rd_data_q;
          pos_d   = par_q;
          state_d = dmhq_pkg::StUpChk;
        end else begin
          state_d = dmhq_pkg::StDone;
        end
      end
      dmhq_pkg::StRoot: begin
        res_key_d = rd_data_q[EW-1 -: KEY_WIDTH];
        res_tag_d = rd_data_q[TAG_WIDTH-1:0];
        if (mode_q == dmhq_pkg::ModePeek) begin
          state_d = dmhq_pkg::StDone;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(count_q - CW'(1));
          count_d = count_q - CW'(1);
          state_d = dmhq_pkg::StLast;
        end
      end
      dmhq_pkg::StLast: begin
        hold_d  = rd_data_q;
        pos_d   = '0;
        state_d = dmhq_pkg::StDnFirst;
      end
      dmhq_pkg::StDnFirst: begin
        if (first_c >= FW'(count_q)) begin
          wr_en   = 1'b1;
          state_d = dmhq_pkg::StDone;
        end else begin
          ch_d     = IW'(first_c);
          ch_end_d = (last_c >= FW'(count_q)) ? IW'(count_q - CW'(1)) : IW'(last_c);
          best_v_d = 1'b0;
          state_d  = dmhq_pkg::StDnRd;
        end
      end
      dmhq_pkg::StDnRd: begin
        rd_en    = 1'b1;
        rd_addr  = ch_q;
        rdv_d    = 1'b1;
        rd_idx_d = ch_q;
        if (ch_q == ch_end_q) begin
          state_d = dmhq_pkg::StDnWait;
        end else begin
          ch_d = ch_q + IW'(1);
        end
      end
      dmhq_pkg::StDnWait: begin
        state_d = dmhq_pkg::StDnDec;
      end
      dmhq_pkg::StDnDec: begin
        wr_en = 1'b1;
        if (hold_q[EW-1 -: KEY_WIDTH] > best_q[EW-1 -: KEY_WIDTH]) begin
          wr_data = best_q;
          pos_d   = best_idx_q;
          state_d = dmhq_pkg::StDnFirst;
        end else begin
          state_d = dmhq_pkg::StDone;
        end
      end
      dmhq_pkg::StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = dmhq_pkg::StIdle;
        end
      end
      default: state_d = dmhq_pkg::StIdle;
    endcase
  end

  // output register: hold a result until its transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = OUTW'({count_q, res_st_q, res_tag_q, res_key_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmhq_pkg::StIdle;
      count_q     <= '0;
      arity_q     <= AW'(dmhq_pkg::ArityReset);
      out_valid_q <= 1'b0;
      rdv_q       <= 1'b0;
      best_v_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      arity_q     <= arity_d;
      out_valid_q <= out_valid_d;
      rdv_q       <= rdv_d;
      best_v_q    <= best_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    hold_q     <= hold_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    pos_q      <= pos_d;
    quo_q      <= quo_d;
    par_q      <= par_d;
    ch_q       <= ch_d;
    ch_end_q   <= ch_end_d;
    rd_idx_q   <= rd_idx_d;
    res_key_q  <= res_key_d;
    res_tag_q  <= res_tag_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_arity_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (arity_q >= AW'(dmhq_pkg::ArityMin)) && (arity_q <= AW'(MAX_ARITY)))
    else $error("arity out of range");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == dmhq_pkg::StDone))
    else $error("result loaded outside done state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q != dmhq_pkg::StIdle))
    else $error("accepted item left unit idle");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("memory read and write in one cycle");

endmodule
